/* design/fdc_pkg.sv */
// fan duty controller package: configuration and result types, reset values,
// ladder and band constants, and small duty helpers
// no dependencies
package fdc_pkg;

	typedef struct packed {
		logic signed [7:0] hot_enter;
		logic signed [7:0] hot_exit;
		logic signed [7:0] cold_enter;
		logic signed [7:0] cold_exit;
		logic [6:0]        max_duty;
		logic [6:0]        min_duty;
		logic [5:0]        duty_step;
	} fdc_cfg_t;

	typedef struct packed {
		logic [6:0]  duty;
		logic [13:0] count;
		logic        forced_max;
		logic        forced_min;
		logic        warming;
	} fdc_result_t;

	// register indexes
	localparam logic [2:0] REG_HOT_ENTER    = 3'd0;
	localparam logic [2:0] REG_HOT_EXIT     = 3'd1;
	localparam logic [2:0] REG_COLD_ENTER   = 3'd2;
	localparam logic [2:0] REG_COLD_EXIT    = 3'd3;
	localparam logic [2:0] REG_MAX_DUTY     = 3'd4;
	localparam logic [2:0] REG_MIN_DUTY     = 3'd5;
	localparam logic [2:0] REG_DUTY_STEP    = 3'd6;
	localparam logic [2:0] REG_INITIAL_DUTY = 3'd7;

	// register reset values
	localparam logic signed [7:0] HOT_ENTER_RST  = 8'sd68;
	localparam logic signed [7:0] HOT_EXIT_RST   = 8'sd60;
	localparam logic signed [7:0] COLD_ENTER_RST = 8'sd30;
	localparam logic signed [7:0] COLD_EXIT_RST  = 8'sd35;
	localparam logic [6:0]        MAX_DUTY_RST   = 7'd100;
	localparam logic [6:0]        MIN_DUTY_RST   = 7'd10;
	localparam logic [5:0]        DUTY_STEP_RST  = 6'd5;
	localparam logic [6:0]        INIT_DUTY_RST  = 7'd30;

	// state reset values and the duty saturation limit
	localparam logic [6:0] BACKUP_DUTY_RST = 7'd80;
	localparam logic [6:0] BAND_DUTY_RST   = 7'd30;
	localparam logic [6:0] HIGH_LIMIT_RST  = 7'd100;
	localparam logic [6:0] DUTY_MAX_LIMIT  = 7'd127;

	// duty after leaving forced minimum
	localparam logic [7:0] COLD_LEAVE_DUTY = 8'd30;

	// warm-up ladder
	localparam logic signed [7:0] WARM_T40 = 8'sd40;
	localparam logic signed [7:0] WARM_T45 = 8'sd45;
	localparam logic signed [7:0] WARM_T50 = 8'sd50;
	localparam logic signed [7:0] WARM_T55 = 8'sd55;
	localparam logic signed [7:0] WARM_T60 = 8'sd60;
	localparam logic [7:0] LADDER_D40  = 8'd40;
	localparam logic [7:0] LADDER_D50  = 8'd50;
	localparam logic [7:0] LADDER_D60  = 8'd60;
	localparam logic [7:0] LADDER_D70  = 8'd70;
	localparam logic [7:0] LADDER_D100 = 8'd100;
	localparam logic [6:0] REWARM_LOW  = 7'd50;
	localparam logic [6:0] REWARM_HIGH = 7'd60;

	// regulation band
	localparam logic signed [8:0] BAND_LO_OFS = 9'sd8;
	localparam logic signed [8:0] BAND_HI_OFS = 9'sd4;
	localparam logic [3:0]        COOL_DWELL  = 4'd10;
	localparam logic [2:0]        HOT_DWELL   = 3'd5;

	// percent * 8192 / 100 as (d * ceil(2^24/25)) >> 13, exact for d < 128
	localparam logic [26:0] DC_RECIP = 27'd671089;

	function automatic logic [13:0] duty_count_f(input logic [6:0] d);
		logic [26:0] p;
		p = 27'(d) * DC_RECIP;
		return p[26:13];
	endfunction

	function automatic logic [6:0] clamp_hi(input logic [7:0] v, input logic [6:0] mx);
		return (v > {1'b0, mx}) ? mx : v[6:0];
	endfunction

	// one step up, held under both the maximum and the learned high limit
	function automatic logic [6:0] step_up(input logic [6:0] b, input logic [5:0] st,
			input logic [6:0] mx, input logic [6:0] hl);
		logic [7:0] s;
		s = {1'b0, b} + {2'b00, st};
		if (s > {1'b0, mx})
			s = {1'b0, mx};
		if (s > {1'b0, hl})
			s = {1'b0, hl};
		return s[6:0];
	endfunction

endpackage

/* design/fan_thermal_duty_controller_unit.sv */
// fan thermal duty controller, top level: input register, tick update, result register
// depends on fdc_pkg, fdc_cfg, fdc_core
//
// usage:
//  - input channel (in_valid/in_ready/temperature): one transfer is one control tick
//    carrying the hottest board temperature in signed degrees
//  - output channel (out_valid/out_ready/...): exactly one result per tick, in order,
//    with duty in percent, its 14-bit pwm count and the mode flags
//  - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//    only while no tick is in flight
//  - path: a tick accepted into the input register moves on to the result register
//    when the output is free, and out_valid rises as it is loaded there
//  - throughput: one tick per cycle without a stall; the state is read and rewritten
//    in the same cycle the tick leaves the input register, so the loop sets the rate
//  - a stalled receiver holds the result register; one more tick waits in the input
//    register, after that in_ready drops until the result is taken
//  - reset clears both registers and loads all registers and the duty state with
//    their reset values (duty starts at 30 percent)
module fan_thermal_duty_controller_unit import fdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [7:0] temperature,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        duty_percent,
	output logic [13:0]       duty_count,
	output logic              forced_max,
	output logic              forced_min,
	output logic              warming
);

	fdc_cfg_t          cfg;
	fdc_result_t       res, res_q;
	logic signed [7:0] temp_s1;
	logic              valid_s1, out_valid_q, advance;

	assign cfg_ready = 1'b1;

	fdc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the tick moves to the result register when that one is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	fdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance),
		.temp   (temp_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			temp_s1 <= temperature;
		if (advance)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign duty_percent = res_q.duty;
	assign duty_count   = res_q.count;
	assign forced_max   = res_q.forced_max;
	assign forced_min   = res_q.forced_min;
	assign warming      = res_q.warming;

endmodule

/* design/fdc_cfg.sv */
// fan duty controller configuration registers
// depends on fdc_pkg
module fdc_cfg import fdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output fdc_cfg_t   cfg
);

	fdc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hot_enter  <= HOT_ENTER_RST;
			cfg_q.hot_exit   <= HOT_EXIT_RST;
			cfg_q.cold_enter <= COLD_ENTER_RST;
			cfg_q.cold_exit  <= COLD_EXIT_RST;
			cfg_q.max_duty   <= MAX_DUTY_RST;
			cfg_q.min_duty   <= MIN_DUTY_RST;
			cfg_q.duty_step  <= DUTY_STEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_HOT_ENTER:  cfg_q.hot_enter  <= wr_data;
				REG_HOT_EXIT:   cfg_q.hot_exit   <= wr_data;
				REG_COLD_ENTER: cfg_q.cold_enter <= wr_data;
				REG_COLD_EXIT:  cfg_q.cold_exit  <= wr_data;
				REG_MAX_DUTY:   cfg_q.max_duty   <= wr_data[6:0];
				REG_MIN_DUTY:   cfg_q.min_duty   <= wr_data[6:0];
				REG_DUTY_STEP:  cfg_q.duty_step  <= wr_data[5:0];
				// initial duty only acts at reset, where it always holds its reset value
				REG_INITIAL_DUTY: ;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/fdc_core.sv */
// fan duty controller state and tick update, computed combinationally and registered on tick
// depends on fdc_pkg
module fdc_core import fdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic signed [7:0] temp,
	input  fdc_cfg_t          cfg,
	output fdc_result_t       res
);

	logic [6:0]        duty_q, backup_q, band_q, low_lim_q, high_lim_q, low_ent_q, high_ent_q;
	logic [3:0]        cool_q;
	logic [2:0]        hot_q;
	logic signed [7:0] cool_start_q;
	logic              done_q, max_q, max_left_q, min_q, min_left_q, warm_q;

	logic [6:0]        nd, nbackup, nband, nlow, nhigh, nlowe, nhighe;
	logic [3:0]        ncool;
	logic [2:0]        nhot;
	logic signed [7:0] nstart;
	logic              ndone, nmax, nmaxl, nmin, nminl, nwarm, acted;
	logic signed [8:0] t9, band_lo, band_hi, vdec;
	logic [7:0]        sum8;

	always_comb begin
		nd = duty_q;  nbackup = backup_q;  nband = band_q;
		nlow = low_lim_q;  nhigh = high_lim_q;  nlowe = low_ent_q;  nhighe = high_ent_q;
		ncool = cool_q;  nhot = hot_q;  nstart = cool_start_q;
		ndone = done_q;  nmax = max_q;  nmaxl = max_left_q;
		nmin = min_q;  nminl = min_left_q;  nwarm = warm_q;
		acted = 1'b0;
		vdec = '0;
		sum8 = '0;
		t9 = {temp[7], temp};
		band_lo = {cfg.hot_enter[7], cfg.hot_enter} - BAND_LO_OFS;
		band_hi = {cfg.hot_enter[7], cfg.hot_enter} - BAND_HI_OFS;

		// over-temperature: force max, remember where we were; on cooling, return one step above it
		if (temp >= cfg.hot_enter && duty_q != cfg.max_duty) begin
			nbackup = duty_q;
			nd = cfg.max_duty;
			nmax = 1'b1;  nmaxl = 1'b0;  acted = 1'b1;
		end else if (temp <= cfg.hot_exit && duty_q == cfg.max_duty) begin
			nd = clamp_hi({1'b0, backup_q} + {2'b00, cfg.duty_step}, cfg.max_duty);
			nmax = 1'b0;  nmaxl = 1'b1;  acted = 1'b1;
		end

		if (temp <= cfg.cold_enter) begin
			nd = clamp_hi({1'b0, cfg.min_duty}, cfg.max_duty);
			nmin = 1'b1;  nminl = 1'b0;  acted = 1'b1;
		end else if (temp >= cfg.cold_exit && nd == cfg.min_duty) begin
			nd = clamp_hi(COLD_LEAVE_DUTY, cfg.max_duty);
			nmin = 1'b0;  nminl = 1'b1;  acted = 1'b1;
		end

		if (!acted && !ndone) begin
			nwarm = 1'b1;
			if (temp <= WARM_T40)
				nd = clamp_hi(LADDER_D40, cfg.max_duty);
			else if (temp <= WARM_T45)
				nd = clamp_hi(LADDER_D50, cfg.max_duty);
			else if (temp <= WARM_T50)
				nd = clamp_hi(LADDER_D60, cfg.max_duty);
			else begin
				nd = clamp_hi((temp <= WARM_T60) ? LADDER_D70 : LADDER_D100, cfg.max_duty);
				ndone = 1'b1;  nwarm = 1'b0;
			end
		end

		// duty no longer fits the temperature: run the ladder again
		if (ndone && ((temp >= WARM_T55 && nd < REWARM_LOW) ||
				(temp < WARM_T40 && nd > REWARM_HIGH))) begin
			ndone = 1'b0;  nwarm = 1'b1;
		end

		if (nmax || nmin || nwarm || nmaxl || nminl) begin
			if (!(nmax || nmin || nwarm)) begin
				nmaxl = 1'b0;  nminl = 1'b0;
			end
			ncool = '0;  nhot = '0;
			nlow = '0;  nhigh = HIGH_LIMIT_RST;
		end else begin
			nband = nd;
			if (t9 < band_lo) begin
				nhot = '0;
				ncool = cool_q + 4'd1;
				if (ncool == 4'd1)
					nstart = temp;
				if (ncool > COOL_DWELL) begin
					if (temp < nstart) begin
						vdec = $signed({2'b00, nband}) - $signed({3'b000, cfg.duty_step});
						if (vdec < $signed({2'b00, cfg.min_duty}))
							vdec = {2'b00, cfg.min_duty};
						if (vdec < $signed({2'b00, nlow}))
							vdec = {2'b00, nlow};
						nband = clamp_hi(vdec[7:0], cfg.max_duty);
						nd = nband;
					end else if (temp > nstart) begin
						nband = step_up(nband, cfg.duty_step, cfg.max_duty, nhigh);
						nd = nband;
					end
					ncool = '0;
				end
			end else if (t9 > band_hi) begin
				ncool = '0;
				nhot = hot_q + 3'd1;
				if (nhot == HOT_DWELL) begin
					nband = step_up(nband, cfg.duty_step, cfg.max_duty, nhigh);
					nd = nband;
					nhot = '0;
				end
			end else begin
				// entering the band from below or above teaches the limits
				if (t9 == band_lo && cool_q != '0) begin
					nlowe = nband;
					if (high_ent_q != '0)
						nhigh = (high_ent_q < {1'b0, cfg.duty_step}) ? '0 :
							high_ent_q - {1'b0, cfg.duty_step};
				end
				if (t9 == band_hi && hot_q != '0) begin
					nhighe = nband;
					if (nlowe != '0) begin
						sum8 = {1'b0, nlowe} + {2'b00, cfg.duty_step};
						nlow = sum8[7] ? DUTY_MAX_LIMIT : sum8[6:0];
					end
				end
				ncool = '0;  nhot = '0;
			end
		end

		res.duty       = nd;
		res.count      = duty_count_f(nd);
		res.forced_max = nmax;
		res.forced_min = nmin;
		res.warming    = nwarm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= INIT_DUTY_RST;
			backup_q     <= BACKUP_DUTY_RST;
			band_q       <= BAND_DUTY_RST;
			low_lim_q    <= '0;
			high_lim_q   <= HIGH_LIMIT_RST;
			low_ent_q    <= '0;
			high_ent_q   <= '0;
			cool_q       <= '0;
			hot_q        <= '0;
			cool_start_q <= '0;
			done_q       <= 1'b0;
			max_q        <= 1'b0;
			max_left_q   <= 1'b0;
			min_q        <= 1'b0;
			min_left_q   <= 1'b0;
			warm_q       <= 1'b0;
		end else if (tick) begin
			duty_q       <= nd;
			backup_q     <= nbackup;
			band_q       <= nband;
			low_lim_q    <= nlow;
			high_lim_q   <= nhigh;
			low_ent_q    <= nlowe;
			high_ent_q   <= nhighe;
			cool_q       <= ncool;
			hot_q        <= nhot;
			cool_start_q <= nstart;
			done_q       <= ndone;
			max_q        <= nmax;
			max_left_q   <= nmaxl;
			min_q        <= nmin;
			min_left_q   <= nminl;
			warm_q       <= nwarm;
		end
	end

endmodule

/* design/fdc_checker.sv */
// port-level checks for the fan duty controller, bound to the top level
// depends on fdc_pkg and fan_thermal_duty_controller_unit
module fdc_checker import fdc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  duty_percent,
	input logic [13:0] duty_count,
	input logic        forced_max,
	input logic        forced_min,
	input logic        warming
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_percent) &&
			$stable(duty_count) && $stable(forced_max) && $stable(forced_min) &&
			$stable(warming))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled, full output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// pwm count tracks the duty percent
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_count == duty_count_f(duty_percent))
		else $error("duty count does not match duty percent");

endmodule

bind fan_thermal_duty_controller_unit fdc_checker u_fdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.duty_percent (duty_percent),
	.duty_count   (duty_count),
	.forced_max   (forced_max),
	.forced_min   (forced_min),
	.warming      (warming)
);
